// File: src/slcp_pkg.sv
// ============================================================================
// SLCAN command parser package
// Shared character codes, result kinds, limits and the bitrate table used by
// the SLCAN command line parser.
// ============================================================================
package slcp_pkg;

    // Character codes of the line.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CMD_CLOSE  = 8'h43;  // 'C'
    localparam logic [7:0] CMD_RATE   = 8'h53;  // 'S'
    localparam logic [7:0] CMD_VER    = 8'h56;  // 'V'
    localparam logic [7:0] CMD_OPEN   = 8'h4F;  // 'O'
    localparam logic [7:0] CMD_STD    = 8'h74;  // 't'
    localparam logic [7:0] CMD_EXT    = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    // Frame limits.
    localparam logic [31:0] STD_ID_MAX    = 32'h0000_07FF;
    localparam logic [31:0] EXT_ID_MAX    = 32'h1FFF_FFFF;
    localparam logic [4:0]  STD_ID_DIGITS = 5'd3;
    localparam logic [4:0]  EXT_ID_DIGITS = 5'd8;
    localparam logic [3:0]  MAX_DLC       = 4'd8;
    localparam logic [4:0]  POS_MAX       = 5'd31;

    // Defaults for the top level.
    localparam int          FIFO_SLOTS_DEFAULT = 8;
    localparam logic [9:0]  FALLBACK_RESET     = 10'd12;

    typedef enum logic [2:0] {
        KIND_CLOSE   = 3'd0,
        KIND_RATE    = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_OPEN    = 3'd3,
        KIND_STD     = 3'd4,
        KIND_EXT     = 3'd5,
        KIND_UNKNOWN = 3'd6
    } kind_t;

    typedef struct packed {
        logic        is_cr;
        logic        hex_ok;
        logic [3:0]  nibble;
        logic        rate_ok;
        logic [3:0]  rate_digit;
    } byte_class_t;

    typedef struct packed {
        logic        status;
        kind_t       kind;
        logic [28:0] frame_id;
        logic        extended;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [9:0]  prescaler;
        logic [2:0]  slot_index;
    } result_t;

    // Prescaler for bitrate digits 0 to 8.
    function automatic logic [9:0] rate_prescaler(input logic [3:0] digit);
        logic [9:0] value;
        case (digit)
            4'd0:    value = 10'd600;
            4'd1:    value = 10'd300;
            4'd2:    value = 10'd120;
            4'd3:    value = 10'd60;
            4'd4:    value = 10'd48;
            4'd5:    value = 10'd24;
            4'd6:    value = 10'd12;
            4'd7:    value = 10'd8;
            4'd8:    value = 10'd6;
            default: value = 10'd600;
        endcase
        return value;
    endfunction

endpackage

// File: src/slcan_command_line_parser.sv
// ============================================================================
// SLCAN command line parser
// Parses the host's ASCII SLCAN command lines one character at a time and
// reports one decoded command for every non-empty line.
// ============================================================================
//
//  Channel   Direction  Handshake                       Beat carries
//  rx        in         rx_valid / rx_ready             rx_byte
//  result    out        result_valid / result_ready     status .. slot_index
//  cfg       in         cfg_valid / cfg_ready           fallback_prescaler
//
// One character is taken in every cycle unless a line-ending carriage return
// is stalled in the input register. A character is held in the input register
// and decoded by the line parser; a carriage return ending a non-empty line
// has its result registered in the result register when the parser advances.
// Reset clears the line state, the slot pointer and both valid flags, and
// sets the fallback prescaler to 12. While a result waits to be taken,
// characters keep flowing, but a carriage return that ends a non-empty
// line waits in the input register until the result register frees up.
// The configuration port is always ready.
//
module slcan_command_line_parser #(
    parameter int FIFO_SLOTS = slcp_pkg::FIFO_SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        status,
    output logic [2:0]  command_kind,
    output logic [28:0] frame_id,
    output logic        extended,
    output logic [3:0]  data_length,
    output logic [63:0] payload,
    output logic [9:0]  prescaler,
    output logic [2:0]  slot_index,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  fallback_prescaler
);

    // Input register: one character waiting to be parsed.
    logic [7:0]        in_byte_reg;
    logic              in_full_reg;

    // Result register and the configuration register.
    slcp_pkg::result_t res_reg;
    logic              res_valid_reg;
    logic [9:0]        fallback_reg;

    slcp_pkg::byte_class_t cls;
    slcp_pkg::result_t     res_next;
    logic                  produce;
    logic                  advance;

    // The parser advances unless it would produce a result into a result
    // register that is still full and not being taken this cycle.
    assign advance   = in_full_reg && (!produce || !res_valid_reg || result_ready);
    assign rx_ready  = !in_full_reg || advance;
    assign cfg_ready = 1'b1;

    slcp_byte_class u_class (
        .data_in (in_byte_reg),
        .cls     (cls)
    );

    slcp_line_parser #(
        .FIFO_SLOTS (FIFO_SLOTS)
    ) u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .data_in            (in_byte_reg),
        .cls                (cls),
        .fallback_prescaler (fallback_reg),
        .produce            (produce),
        .result             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            fallback_reg  <= slcp_pkg::FALLBACK_RESET;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance && produce)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                fallback_reg <= fallback_prescaler;
            end
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = res_reg.status;
    assign command_kind = res_reg.kind;
    assign frame_id     = res_reg.frame_id;
    assign extended     = res_reg.extended;
    assign data_length  = res_reg.data_length;
    assign payload      = res_reg.payload;
    assign prescaler    = res_reg.prescaler;
    assign slot_index   = res_reg.slot_index;

endmodule

// File: src/slcp_byte_class.sv
// ============================================================================
// SLCAN byte classifier
// Decodes one received character into its hex value, bitrate digit and
// end-of-line flag.
// ============================================================================
module slcp_byte_class (
    input  logic [7:0]            data_in,
    output slcp_pkg::byte_class_t cls
);

    logic is_dec;
    logic is_upper;
    logic is_lower;

    assign is_dec   = (data_in >= slcp_pkg::CHAR_ZERO) && (data_in <= slcp_pkg::CHAR_NINE);
    assign is_upper = (data_in >= slcp_pkg::CHAR_UA) && (data_in <= slcp_pkg::CHAR_UF);
    assign is_lower = (data_in >= slcp_pkg::CHAR_LA) && (data_in <= slcp_pkg::CHAR_LF);

    always_comb
    begin
        cls.is_cr      = (data_in == slcp_pkg::CHAR_CR);
        cls.hex_ok     = is_dec || is_upper || is_lower;
        // Letters A-F and a-f both carry their value minus nine in the low nibble.
        cls.nibble     = is_dec ? data_in[3:0] : 4'(data_in[3:0] + 4'd9);
        cls.rate_ok    = (data_in >= slcp_pkg::CHAR_ZERO) && (data_in <= slcp_pkg::CHAR_EIGHT);
        cls.rate_digit = data_in[3:0];
    end

endmodule

// File: src/slcp_line_parser.sv
// ============================================================================
// SLCAN line parser
// Holds the state of the line being received, updates it one character per
// step and forms the result when a carriage return ends a non-empty line.
// ============================================================================
module slcp_line_parser #(
    parameter int FIFO_SLOTS = slcp_pkg::FIFO_SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_in,
    input  slcp_pkg::byte_class_t cls,
    input  logic [9:0]            fallback_prescaler,
    output logic                  produce,
    output slcp_pkg::result_t     result
);

    localparam int              SLOT_W    = $clog2(FIFO_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FIFO_SLOTS - 1);

    logic [7:0]        cmd_reg,   cmd_next;
    logic [4:0]        pos_reg,   pos_next;
    logic [31:0]       id_reg,    id_next;
    logic [3:0]        len_reg,   len_next;
    logic [63:0]       data_reg,  data_next;
    logic [3:0]        rate_reg,  rate_next;
    logic              err_reg,   err_next;
    logic [SLOT_W-1:0] slot_reg,  slot_next;

    logic [4:0] k;
    logic [4:0] idn;
    logic [4:0] data_idx;
    logic [5:0] frame_len;
    logic       frame_bad;
    logic       err_end;

    assign k         = pos_reg - 5'd1;
    assign idn       = (cmd_reg == slcp_pkg::CMD_STD) ? slcp_pkg::STD_ID_DIGITS
                                                      : slcp_pkg::EXT_ID_DIGITS;
    assign data_idx  = k - idn - 5'd1;
    assign frame_len = {1'b0, idn} + 6'd2 + {1'b0, len_reg, 1'b0};
    assign produce   = cls.is_cr && (pos_reg != 5'd0);

    // Length and identifier checks applied when a frame line ends.
    always_comb
    begin
        frame_bad = err_reg
                 || ({1'b0, pos_reg} < ({1'b0, idn} + 6'd2))
                 || (len_reg > slcp_pkg::MAX_DLC)
                 || ({1'b0, pos_reg} != frame_len);
        if (cmd_reg == slcp_pkg::CMD_STD)
        begin
            frame_bad = frame_bad || (id_reg > slcp_pkg::STD_ID_MAX);
        end
        else
        begin
            frame_bad = frame_bad || (id_reg > slcp_pkg::EXT_ID_MAX);
        end
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        pos_next  = pos_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        data_next = data_reg;
        rate_next = rate_reg;
        err_next  = err_reg;
        slot_next = slot_reg;
        err_end   = err_reg;

        result             = '0;
        result.kind        = slcp_pkg::KIND_UNKNOWN;

        if (!cls.is_cr)
        begin
            if (pos_reg == 5'd0)
            begin
                cmd_next = data_in;
            end
            else
            begin
                case (cmd_reg)
                    slcp_pkg::CMD_STD, slcp_pkg::CMD_EXT:
                    begin
                        if (!cls.hex_ok)
                        begin
                            err_next = 1'b1;
                        end
                        else if (k < idn)
                        begin
                            id_next = {id_reg[27:0], cls.nibble};
                        end
                        else if (k == idn)
                        begin
                            len_next = cls.nibble;
                            if (cls.nibble > slcp_pkg::MAX_DLC)
                            begin
                                err_next = 1'b1;
                            end
                        end
                        else if ((len_reg <= slcp_pkg::MAX_DLC)
                                 && (data_idx < {len_reg, 1'b0}))
                        begin
                            data_next = {data_reg[59:0], cls.nibble};
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    slcp_pkg::CMD_RATE:
                    begin
                        if ((k == 5'd0) && cls.rate_ok)
                        begin
                            rate_next = cls.rate_digit;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    slcp_pkg::CMD_CLOSE, slcp_pkg::CMD_VER, slcp_pkg::CMD_OPEN:
                    begin
                        err_next = 1'b1;
                    end
                    default:
                    begin
                        // Unknown commands ignore the rest of the line.
                    end
                endcase
            end
            if (pos_reg < slcp_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
        else if (pos_reg != 5'd0)
        begin
            case (cmd_reg)
                slcp_pkg::CMD_CLOSE:
                begin
                    result.kind = slcp_pkg::KIND_CLOSE;
                    err_end     = err_reg || (pos_reg != 5'd1);
                end
                slcp_pkg::CMD_RATE:
                begin
                    result.kind      = slcp_pkg::KIND_RATE;
                    err_end          = err_reg || (pos_reg != 5'd2);
                    result.prescaler = err_end ? fallback_prescaler
                                               : slcp_pkg::rate_prescaler(rate_reg);
                end
                slcp_pkg::CMD_VER:
                begin
                    result.kind = slcp_pkg::KIND_VERSION;
                    err_end     = err_reg || (pos_reg != 5'd1);
                end
                slcp_pkg::CMD_OPEN:
                begin
                    result.kind = slcp_pkg::KIND_OPEN;
                    err_end     = err_reg || (pos_reg != 5'd1);
                    slot_next   = '0;
                end
                slcp_pkg::CMD_STD, slcp_pkg::CMD_EXT:
                begin
                    result.kind = (cmd_reg == slcp_pkg::CMD_STD) ? slcp_pkg::KIND_STD
                                                                 : slcp_pkg::KIND_EXT;
                    err_end     = frame_bad;
                    if (!frame_bad)
                    begin
                        result.frame_id    = id_reg[28:0];
                        result.extended    = (cmd_reg == slcp_pkg::CMD_EXT);
                        result.data_length = len_reg;
                        result.payload     = data_reg;
                        result.slot_index  = 3'(slot_reg);
                        slot_next          = (slot_reg == SLOT_LAST) ? '0
                                                                     : slot_reg + 1'b1;
                    end
                end
                default:
                begin
                    result.kind = slcp_pkg::KIND_UNKNOWN;
                    err_end     = 1'b1;
                end
            endcase
            result.status = err_end;

            cmd_next  = '0;
            pos_next  = '0;
            id_next   = '0;
            len_next  = '0;
            data_next = '0;
            rate_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= '0;
            pos_reg  <= '0;
            id_reg   <= '0;
            len_reg  <= '0;
            data_reg <= '0;
            rate_reg <= '0;
            err_reg  <= 1'b0;
            slot_reg <= '0;
        end
        else if (step)
        begin
            cmd_reg  <= cmd_next;
            pos_reg  <= pos_next;
            id_reg   <= id_next;
            len_reg  <= len_next;
            data_reg <= data_next;
            rate_reg <= rate_next;
            err_reg  <= err_next;
            slot_reg <= slot_next;
        end
    end

endmodule
